// ===== rtl/smt_aware_cpu_selector_top_defines.svh =====
// ----------------------------------------------------------------------------
// smt_aware_cpu_selector_top_defines
// Assertion macros shared by the selector modules.
// ----------------------------------------------------------------------------
`ifndef SMT_AWARE_CPU_SELECTOR_TOP_DEFINES_SVH
`define SMT_AWARE_CPU_SELECTOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SMTSEL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smtsel same-cycle check failed");

// next-cycle implication
`define SMTSEL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smtsel next-cycle check failed");

`else

`define SMTSEL_ASSERT_SAME(lbl, ante, cons)
`define SMTSEL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/smtsel_pkg.sv =====
// ----------------------------------------------------------------------------
// smtsel_pkg
// Types, constants and helper functions of the SMT-aware CPU selector.
// ----------------------------------------------------------------------------
package smtsel_pkg;

  // default table depth
  localparam int NUM_CPUS_DEF = 32;

  // wide index / count width (covers 64 CPUs and pin index plus one)
  localparam int XW = 7;

  // field widths
  localparam int CORE_W   = 5;
  localparam int SMT_W    = 5;
  localparam int LOAD_W   = 11;
  localparam int THR_W    = 16;
  localparam int ELOAD_W  = 14;
  localparam int FACTOR_W = 8;
  localparam int ACT_W    = 6;
  localparam int MASK_W   = 32;
  localparam int SIB_W    = 17;  // sum of up to 64 loads
  localparam int PROD_W   = SIB_W + FACTOR_W;
  localparam int TOT_W    = SIB_W + 1;
  localparam int FACTOR_FRAC = 8;

  // effective load saturation and "no SMT id" code
  localparam logic [ELOAD_W-1:0] LOAD_SAT = '1;
  localparam logic [SMT_W-1:0]   SMT_NONE = '1;

  // configuration port
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

  // register reset values
  localparam logic [ACT_W-1:0]    ACTIVE_RST = 6'd32;
  localparam logic [FACTOR_W-1:0] FACTOR_RST = 8'd128;
  localparam logic [ELOAD_W-1:0]  LIMIT_RST  = 14'd768;

  // one table entry
  typedef struct packed {
    logic              enabled;
    logic [CORE_W-1:0] core;
    logic [SMT_W-1:0]  smt;
    logic [LOAD_W-1:0] load;
    logic [THR_W-1:0]  threads;
    logic              idle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath commands
  typedef struct packed {
    logic          wr;      // write one table entry
    logic          latch;   // capture a choose word
    logic          pin_rd;  // read pinned entry, clear accumulators
    logic          sum_rd;  // sibling sum pass read
    logic          sel_rd;  // selection pass read
    logic          finish;  // form the result
    logic [XW-1:0] addr;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [XW-1:0] count;  // CPUs present
  } stat_t;

  // own load plus weighted sibling load, saturated
  function automatic logic [ELOAD_W-1:0] eff_load(input logic [LOAD_W-1:0]   ld,
                                                  input logic [SIB_W-1:0]    sib,
                                                  input logic [FACTOR_W-1:0] f);
    logic [PROD_W-1:0] prod;
    logic [TOT_W-1:0]  tot;
    prod = PROD_W'(sib) * PROD_W'(f);
    tot  = TOT_W'(ld) + TOT_W'(prod[PROD_W-1:FACTOR_FRAC]);
    return (tot > TOT_W'(LOAD_SAT)) ? LOAD_SAT : tot[ELOAD_W-1:0];
  endfunction

endpackage

// ===== rtl/smtsel_ram.sv =====
// ----------------------------------------------------------------------------
// smtsel_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module smtsel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/smtsel_ctrl.sv =====
// ----------------------------------------------------------------------------
// smtsel_ctrl
// Sequencer: table writes, pinned entry read, sibling sum pass, selection pass, drain, result.
// ----------------------------------------------------------------------------
`include "smt_aware_cpu_selector_top_defines.svh"

module smtsel_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                command,
  output logic                busy,
  output smtsel_pkg::cmd_t    cmd,
  input  smtsel_pkg::stat_t   stat
);

  localparam int XW = smtsel_pkg::XW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PIN    = 3'd1;
  localparam logic [2:0] ST_SUM    = 3'd2;
  localparam logic [2:0] ST_SEL    = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]    state, state_next;
  logic [XW-1:0] cnt, cnt_next;
  logic [1:0]    dcnt, dcnt_next;
  logic          accept;
  logic          last;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign last   = ((cnt + XW'(1)) >= stat.count);

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    dcnt_next  = dcnt;
    cmd        = '0;
    cmd.addr   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept && command) begin
          cmd.latch  = 1'b1;
          state_next = ST_PIN;
        end else if (accept) begin
          cmd.wr = 1'b1;
        end
      end
      ST_PIN: begin
        cmd.pin_rd = 1'b1;
        cnt_next   = '0;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_rd = (cnt < stat.count);
        if (last) begin
          cnt_next   = '0;
          state_next = ST_SEL;
        end else begin
          cnt_next = cnt + XW'(1);
        end
      end
      ST_SEL: begin
        cmd.sel_rd = (cnt < stat.count);
        if (last) begin
          cnt_next   = '0;
          dcnt_next  = '0;
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + XW'(1);
        end
      end
      ST_DRAIN: begin
        dcnt_next = dcnt + 2'd1;
        if (dcnt == 2'd2) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      dcnt  <= dcnt_next;
    end
  end

  `SMTSEL_ASSERT_SAME(a_rd_in_range, cmd.sum_rd || cmd.sel_rd, cmd.addr < stat.count)
  `SMTSEL_ASSERT_NEXT(a_choose_starts, start && !busy && command, state == ST_PIN)
  `SMTSEL_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0({cmd.wr, cmd.latch, cmd.pin_rd, cmd.sum_rd, cmd.sel_rd, cmd.finish}))

endmodule

// ===== rtl/smtsel_dp.sv =====
// ----------------------------------------------------------------------------
// smtsel_dp
// Datapath: config registers, CPU table, sibling sums, load pipe, trackers.
// ----------------------------------------------------------------------------
`include "smt_aware_cpu_selector_top_defines.svh"

module smtsel_dp #(
  parameter int NUM_CPUS = smtsel_pkg::NUM_CPUS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  smtsel_pkg::cmd_t                      cmd,
  output smtsel_pkg::stat_t                     stat,
  input  logic [4:0]                            cpu_index,
  input  logic [smtsel_pkg::CORE_W-1:0]         core,
  input  logic                                  enabled,
  input  logic signed [smtsel_pkg::SMT_W-1:0]   smt_id,
  input  logic [smtsel_pkg::LOAD_W-1:0]         load,
  input  logic [smtsel_pkg::THR_W-1:0]          thread_count,
  input  logic                                  running_idle,
  input  logic [smtsel_pkg::MASK_W-1:0]         affinity_mask,
  input  logic signed [5:0]                     last_cpu,
  input  logic [5:0]                            pinned_cpu,
  input  logic signed [5:0]                     current_cpu,
  input  logic                                  cfg_write,
  input  logic [smtsel_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smtsel_pkg::CFG_W-1:0]          cfg_data,
  output logic                                  done,
  output logic [4:0]                            chosen_cpu,
  output logic                                  found,
  output logic                                  reschedule,
  output logic [smtsel_pkg::ELOAD_W-1:0]        chosen_load
);

  localparam int IW      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int XW      = smtsel_pkg::XW;
  localparam int SIB_W   = smtsel_pkg::SIB_W;
  localparam int ELOAD_W = smtsel_pkg::ELOAD_W;
  localparam int THR_W   = smtsel_pkg::THR_W;
  localparam int LOAD_W  = smtsel_pkg::LOAD_W;
  localparam int NSMT    = 2 ** smtsel_pkg::SMT_W;

  // configuration registers
  logic [smtsel_pkg::ACT_W-1:0]    active_cpus;
  logic [smtsel_pkg::FACTOR_W-1:0] factor;
  logic [ELOAD_W-1:0]              limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cpus <= smtsel_pkg::ACTIVE_RST;
      factor      <= smtsel_pkg::FACTOR_RST;
      limit       <= smtsel_pkg::LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        smtsel_pkg::CFG_ACTIVE: active_cpus <= cfg_data[smtsel_pkg::ACT_W-1:0];
        smtsel_pkg::CFG_FACTOR: factor      <= cfg_data[smtsel_pkg::FACTOR_W-1:0];
        smtsel_pkg::CFG_LIMIT:  limit       <= cfg_data[ELOAD_W-1:0];
        default: ;
      endcase
    end
  end

  // present CPU count
  assign stat.count = (XW'(active_cpus) > XW'(NUM_CPUS)) ? XW'(NUM_CPUS) : XW'(active_cpus);

  // choose word capture
  logic [smtsel_pkg::CORE_W-1:0] tgt_core;
  logic [smtsel_pkg::MASK_W-1:0] mask;
  logic [5:0]                    prev_q, pin_q, cur_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      tgt_core <= core;
      mask     <= affinity_mask;
      prev_q   <= last_cpu;
      pin_q    <= pinned_cpu;
      cur_q    <= current_cpu;
    end
  end

  logic [XW-1:0] pin_idx_x;
  logic          pin_ok;
  assign pin_idx_x = XW'(pin_q) - XW'(1);
  assign pin_ok    = (pin_q != '0) && (pin_idx_x < stat.count);

  // cpu table with valid bits
  logic                    wr_en;
  logic [IW-1:0]           waddr, raddr;
  smtsel_pkg::entry_t      wentry;
  logic [smtsel_pkg::ENTRY_W-1:0] ram_q;
  logic [NUM_CPUS-1:0]     valid;

  assign wr_en  = cmd.wr && (XW'(cpu_index) < XW'(NUM_CPUS));
  assign waddr  = IW'(cpu_index);
  assign raddr  = cmd.pin_rd ? IW'(pin_idx_x) : IW'(cmd.addr);
  assign wentry = '{enabled: enabled, core: core, smt: smt_id, load: load,
                    threads: thread_count, idle: running_idle};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[waddr] <= 1'b1;
    end
  end

  smtsel_ram #(
    .WIDTH (smtsel_pkg::ENTRY_W),
    .DEPTH (NUM_CPUS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // read tags, aligned with the registered read data
  logic          rd_pin, rd_sum, rd_sel, rd_hit;
  logic [IW-1:0] rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pin <= 1'b0;
      rd_sum <= 1'b0;
      rd_sel <= 1'b0;
      rd_hit <= 1'b0;
    end else begin
      rd_pin <= cmd.pin_rd;
      rd_sum <= cmd.sum_rd;
      rd_sel <= cmd.sel_rd;
      rd_hit <= (XW'(raddr) < XW'(NUM_CPUS)) && valid[raddr];
    end
    rd_idx <= raddr;
  end

  // an entry never written reads as zero
  smtsel_pkg::entry_t ent;
  assign ent = rd_hit ? smtsel_pkg::entry_t'(ram_q) : '0;

  // pinned entry and its sibling sum against its own core
  smtsel_pkg::entry_t pin_ent;
  logic [SIB_W-1:0]   pin_acc;
  logic               pin_sib_hit;

  assign pin_sib_hit = rd_sum && ent.enabled && (ent.core == pin_ent.core) &&
                       (ent.smt == pin_ent.smt) && (rd_idx != IW'(pin_idx_x));

  always_ff @(posedge clk) begin
    if (rd_pin) begin
      pin_ent <= ent;
    end
    if (cmd.pin_rd) begin
      pin_acc <= '0;
    end else if (pin_sib_hit) begin
      pin_acc <= pin_acc + SIB_W'(ent.load);
    end
  end

  // per-SMT-id load sums on the target core
  logic [SIB_W-1:0] smt_sum [NSMT];
  logic             self_in;

  assign self_in = ent.enabled && (ent.core == tgt_core);

  always_ff @(posedge clk) begin
    if (cmd.pin_rd) begin
      for (int s = 0; s < NSMT; s++) begin
        smt_sum[s] <= '0;
      end
    end else if (rd_sum && self_in) begin
      smt_sum[ent.smt] <= smt_sum[ent.smt] + SIB_W'(ent.load);
    end
  end

  // selection stage 1: sibling load and eligibility
  logic [SIB_W-1:0] sib_raw;
  logic             mask_ok;

  assign sib_raw = (ent.smt == smtsel_pkg::SMT_NONE) ? '0 :
                   (smt_sum[ent.smt] - (self_in ? SIB_W'(ent.load) : '0));
  assign mask_ok = (mask == '0) ||
                   ((XW'(rd_idx) < XW'(smtsel_pkg::MASK_W)) && mask[5'(rd_idx)]);

  logic              s2_v, s2_ok, s2_idle;
  logic [IW-1:0]     s2_idx;
  logic [LOAD_W-1:0] s2_load;
  logic [SIB_W-1:0]  s2_sib;
  logic [THR_W-1:0]  s2_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= rd_sel;
    end
    s2_ok   <= self_in && mask_ok;
    s2_idx  <= rd_idx;
    s2_load <= ent.load;
    s2_sib  <= sib_raw;
    s2_thr  <= ent.threads;
    s2_idle <= ent.idle;
  end

  // selection stage 2: effective load
  logic               s3_v, s3_ok, s3_idle;
  logic [IW-1:0]      s3_idx;
  logic [ELOAD_W-1:0] s3_eff;
  logic [THR_W-1:0]   s3_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    s3_ok   <= s2_ok;
    s3_idx  <= s2_idx;
    s3_eff  <= smtsel_pkg::eff_load(s2_load, s2_sib, factor);
    s3_thr  <= s2_thr;
    s3_idle <= s2_idle;
  end

  // selection stage 3: previous, best and first-eligible trackers
  logic               cand;
  logic               prev_hit, best_take;
  logic               prev_have, best_have, first_have;
  logic [IW-1:0]      best_idx, first_idx;
  logic [ELOAD_W-1:0] prev_eff, best_eff, first_eff;
  logic [THR_W-1:0]   best_thr;
  logic               prev_idle, best_idle, first_idle;

  assign cand      = s3_v && s3_ok;
  assign prev_hit  = cand && !prev_q[5] && (XW'(s3_idx) == XW'(prev_q[4:0])) &&
                     (s3_eff < limit);
  assign best_take = cand && (!best_have || (s3_eff < best_eff) ||
                     ((s3_eff == best_eff) && (s3_thr < best_thr)));

  always_ff @(posedge clk) begin
    if (rst || cmd.pin_rd) begin
      prev_have  <= 1'b0;
      best_have  <= 1'b0;
      first_have <= 1'b0;
    end else begin
      if (prev_hit) begin
        prev_have <= 1'b1;
      end
      if (best_take) begin
        best_have <= 1'b1;
      end
      if (cand) begin
        first_have <= 1'b1;
      end
    end
    if (prev_hit) begin
      prev_eff  <= s3_eff;
      prev_idle <= s3_idle;
    end
    if (best_take) begin
      best_idx  <= s3_idx;
      best_eff  <= s3_eff;
      best_thr  <= s3_thr;
      best_idle <= s3_idle;
    end
    if (cand && !first_have) begin
      first_idx  <= s3_idx;
      first_eff  <= s3_eff;
      first_idle <= s3_idle;
    end
  end

  // final decision: pin, previous, best, then first eligible
  logic               res_have, res_idle;
  logic [IW-1:0]      res_idx;
  logic [ELOAD_W-1:0] res_eff, pin_eff;
  logic [SIB_W-1:0]   pin_sib;

  assign pin_sib = (pin_ent.smt == smtsel_pkg::SMT_NONE) ? '0 : pin_acc;
  assign pin_eff = smtsel_pkg::eff_load(pin_ent.load, pin_sib, factor);

  always_comb begin
    res_have = 1'b0;
    res_idx  = '0;
    res_eff  = '0;
    res_idle = 1'b0;
    if (pin_ok) begin
      res_have = 1'b1;
      res_idx  = IW'(pin_idx_x);
      res_eff  = pin_eff;
      res_idle = pin_ent.idle;
    end else if ((pin_q == '0) && prev_have) begin
      res_have = 1'b1;
      res_idx  = IW'(prev_q[4:0]);
      res_eff  = prev_eff;
      res_idle = prev_idle;
    end else if ((pin_q == '0) && best_have) begin
      res_have = 1'b1;
      res_idx  = best_idx;
      res_eff  = best_eff;
      res_idle = best_idle;
    end else if (first_have) begin
      res_have = 1'b1;
      res_idx  = first_idx;
      res_eff  = first_eff;
      res_idle = first_idle;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      found       <= res_have;
      chosen_cpu  <= res_have ? 5'(res_idx) : '0;
      chosen_load <= res_have ? res_eff : '0;
      reschedule  <= res_have && (res_idle || cur_q[5] ||
                     (XW'(cur_q[4:0]) != XW'(res_idx)));
    end
  end

  `SMTSEL_ASSERT_NEXT(a_single_strobe, done, !done)
  `SMTSEL_ASSERT_SAME(a_empty_zero, done && !found, chosen_cpu == '0 && chosen_load == '0 && !reschedule)

endmodule

// ===== rtl/smt_aware_cpu_selector_top.sv =====
// ----------------------------------------------------------------------------
// smt_aware_cpu_selector_top
// SMT-aware logical CPU selector: table writes and CPU choose commands.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  -------   ---------            -------
//  command   start / busy         command .. current_cpu
//  config    cfg_write            cfg_index, cfg_data
//  result    done (1-cycle)       chosen_cpu, found, reschedule, chosen_load
//
//  A write word is taken while idle; busy stays low.
//  A choose word raises busy; done rises at the same edge at which busy falls.
//  One pinned-entry read, one table pass for sibling sums, one table pass
//  for selection (one table read port), a three-stage load pipe and a result.
//  Synchronous active-high reset; the table reads as all zero after reset.
//  The result is shown for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module smt_aware_cpu_selector_top #(
  parameter int NUM_CPUS = smtsel_pkg::NUM_CPUS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  command,
  input  logic [4:0]                            cpu_index,
  input  logic [smtsel_pkg::CORE_W-1:0]         core,
  input  logic                                  enabled,
  input  logic signed [smtsel_pkg::SMT_W-1:0]   smt_id,
  input  logic [smtsel_pkg::LOAD_W-1:0]         load,
  input  logic [smtsel_pkg::THR_W-1:0]          thread_count,
  input  logic                                  running_idle,
  input  logic [smtsel_pkg::MASK_W-1:0]         affinity_mask,
  input  logic signed [5:0]                     last_cpu,
  input  logic [5:0]                            pinned_cpu,
  input  logic signed [5:0]                     current_cpu,
  input  logic                                  cfg_write,
  input  logic [smtsel_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smtsel_pkg::CFG_W-1:0]          cfg_data,
  output logic                                  done,
  output logic [4:0]                            chosen_cpu,
  output logic                                  found,
  output logic                                  reschedule,
  output logic [smtsel_pkg::ELOAD_W-1:0]        chosen_load
);

  smtsel_pkg::cmd_t  cmd;
  smtsel_pkg::stat_t stat;

  // sequencer
  smtsel_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .cmd     (cmd),
    .stat    (stat)
  );

  // table, arithmetic and result registers
  smtsel_dp #(
    .NUM_CPUS (NUM_CPUS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cpu_index     (cpu_index),
    .core          (core),
    .enabled       (enabled),
    .smt_id        (smt_id),
    .load          (load),
    .thread_count  (thread_count),
    .running_idle  (running_idle),
    .affinity_mask (affinity_mask),
    .last_cpu      (last_cpu),
    .pinned_cpu    (pinned_cpu),
    .current_cpu   (current_cpu),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .chosen_cpu    (chosen_cpu),
    .found         (found),
    .reschedule    (reschedule),
    .chosen_load   (chosen_load)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SMT-aware CPU selector. Table writes and choose
// words go in through start/busy; every choose result seen on done is checked
// field by field against a predictor that keeps its own copy of the CPU table
// and of the three registers. Directed cases come first, then random phases
// under several register settings, with random gaps on the sender side.
// ----------------------------------------------------------------------------
module tb;
  import smtsel_pkg::*;

  // command codes and the unused register slot
  localparam bit CMD_WRITE  = 1'b0;
  localparam bit CMD_CHOOSE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int SETTLE    = 2 * NUM_CPUS_DEF + 10;  // one choose plus margin
  localparam int DRAIN_CAP = 1000;
  localparam int SHOW_MAX  = 100;

  // one command word
  typedef struct packed {
    bit                cmd;
    bit [4:0]          idx;
    bit [CORE_W-1:0]   core;
    bit                en;
    bit [SMT_W-1:0]    smt;
    bit [LOAD_W-1:0]   load;
    bit [THR_W-1:0]    thr;
    bit                idle;
    bit [MASK_W-1:0]   mask;
    bit [5:0]          prev;
    bit [5:0]          pin;
    bit [5:0]          cur;
  } sel_word_t;

  // one choose result
  typedef struct packed {
    bit [4:0]         cpu;
    bit               found;
    bit               resched;
    bit [ELOAD_W-1:0] eload;
  } sel_result_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic                        command;
  logic [4:0]                  cpu_index;
  logic [CORE_W-1:0]           core;
  logic                        enabled;
  logic signed [SMT_W-1:0]     smt_id;
  logic [LOAD_W-1:0]           load;
  logic [THR_W-1:0]            thread_count;
  logic                        running_idle;
  logic [MASK_W-1:0]           affinity_mask;
  logic signed [5:0]           last_cpu;
  logic [5:0]                  pinned_cpu;
  logic signed [5:0]           current_cpu;
  logic                        cfg_write;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]            cfg_data;
  logic                        done;
  logic [4:0]                  chosen_cpu;
  logic                        found;
  logic                        reschedule;
  logic [ELOAD_W-1:0]          chosen_load;

  smt_aware_cpu_selector_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .cpu_index     (cpu_index),
    .core          (core),
    .enabled       (enabled),
    .smt_id        (smt_id),
    .load          (load),
    .thread_count  (thread_count),
    .running_idle  (running_idle),
    .affinity_mask (affinity_mask),
    .last_cpu      (last_cpu),
    .pinned_cpu    (pinned_cpu),
    .current_cpu   (current_cpu),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .chosen_cpu    (chosen_cpu),
    .found         (found),
    .reschedule    (reschedule),
    .chosen_load   (chosen_load)
  );

  always #2 clk = ~clk;

  // predictor copy of the table and registers
  entry_t             cpu_tbl [NUM_CPUS_DEF];
  bit [ACT_W-1:0]     act_reg;
  bit [FACTOR_W-1:0]  factor_reg;
  bit [ELOAD_W-1:0]   limit_reg;

  sel_result_t expected_q[$];
  sel_result_t head;

  int n_errors;
  int n_writes;
  int n_chooses;
  int n_results;
  int n_settings;

  // sender state
  bit start_up;  // start left high for a back-to-back word
  int next_gap;
  bit calm;      // no idling in this stretch

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= SHOW_MAX) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic bit cpu_usable(input int i, input bit [CORE_W-1:0] tgt,
                                    input bit [MASK_W-1:0] mask);
    return cpu_tbl[i].enabled && cpu_tbl[i].core == tgt && (mask == '0 || mask[i]);
  endfunction

  // own load plus weighted load of enabled same-core siblings, saturated
  function automatic int weighted_load(input int c, input bit [CORE_W-1:0] tgt,
                                       input int n);
    longint unsigned acc;
    longint unsigned tot;
    acc = 0;
    if (cpu_tbl[c].smt != SMT_NONE) begin
      for (int k = 0; k < n; k++) begin
        if (k != c && cpu_tbl[k].enabled && cpu_tbl[k].core == tgt &&
            cpu_tbl[k].smt == cpu_tbl[c].smt)
          acc += 64'(cpu_tbl[k].load) * 64'(factor_reg);
      end
    end
    tot = 64'(cpu_tbl[c].load) + (acc >> FACTOR_FRAC);
    return (tot > 64'(LOAD_SAT)) ? int'(LOAD_SAT) : int'(tot);
  endfunction

  function automatic sel_result_t choose_cpu(input sel_word_t w);
    sel_result_t r;
    int n;
    int pick;
    int best;
    int e;
    bit have;
    n = (act_reg > NUM_CPUS_DEF) ? NUM_CPUS_DEF : int'(act_reg);
    have = 1'b0;
    pick = 0;
    best = 0;
    r = '0;
    // previous cpu kept when usable and lightly loaded
    if (!w.prev[5] && int'(w.prev) < n && cpu_usable(int'(w.prev), w.core, w.mask)) begin
      if (weighted_load(int'(w.prev), w.core, n) < int'(limit_reg)) begin
        have = 1'b1;
        pick = int'(w.prev);
      end
    end
    // pin overrides, else lowest load, fewer threads, lower index
    if (w.pin != 0) begin
      have = (int'(w.pin) - 1) < n;
      pick = have ? int'(w.pin) - 1 : 0;
    end else if (!have) begin
      for (int i = 0; i < n; i++) begin
        if (cpu_usable(i, w.core, w.mask)) begin
          e = weighted_load(i, w.core, n);
          if (!have || e < best) begin
            have = 1'b1;
            pick = i;
            best = e;
          end else if (e == best && cpu_tbl[i].threads < cpu_tbl[pick].threads) begin
            pick = i;
          end
        end
      end
    end
    // last resort: first usable cpu
    if (!have) begin
      for (int i = 0; i < n; i++) begin
        if (!have && cpu_usable(i, w.core, w.mask)) begin
          have = 1'b1;
          pick = i;
        end
      end
    end
    if (have) begin
      r.cpu     = 5'(pick);
      r.found   = 1'b1;
      r.resched = cpu_tbl[pick].idle || w.cur[5] || (int'(w.cur) != pick);
      r.eload   = ELOAD_W'(weighted_load(pick, cpu_tbl[pick].core, n));
    end
    return r;
  endfunction

  function automatic void take_word(input sel_word_t w);
    if (w.cmd == CMD_WRITE) begin
      cpu_tbl[w.idx].enabled = w.en;
      cpu_tbl[w.idx].core    = w.core;
      cpu_tbl[w.idx].smt     = w.smt;
      cpu_tbl[w.idx].load    = w.load;
      cpu_tbl[w.idx].threads = w.thr;
      cpu_tbl[w.idx].idle    = w.idle;
      n_writes++;
    end else begin
      expected_q.push_back(choose_cpu(w));
      n_chooses++;
    end
  endfunction

  // ---------------------------------------------------------------- sender

  task automatic send_word(input sel_word_t w);
    if (!start_up) repeat (next_gap) @(posedge clk);
    command       <= w.cmd;
    cpu_index     <= w.idx;
    core          <= w.core;
    enabled       <= w.en;
    smt_id        <= w.smt;
    load          <= w.load;
    thread_count  <= w.thr;
    running_idle  <= w.idle;
    affinity_mask <= w.mask;
    last_cpu      <= w.prev;
    pinned_cpu    <= w.pin;
    current_cpu   <= w.cur;
    if (!start_up) start <= 1'b1;
    do @(posedge clk); while (busy);
    take_word(w);
    next_gap = calm ? 0 : $urandom_range(0, 14);
    start_up = (next_gap == 0);
    if (!start_up) start <= 1'b0;
  endtask

  task automatic drain_results;
    int waited;
    waited = 0;
    while (expected_q.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    if (expected_q.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_q.size()));
      expected_q.delete();
    end
  endtask

  // stop sending, let every result come back and the block go quiet
  task automatic hold_off;
    if (start_up) start <= 1'b0;
    start_up = 1'b0;
    drain_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_write <= 1'b1;
    @(posedge clk);
    case (idx)
      CFG_ACTIVE: act_reg    = val[ACT_W-1:0];
      CFG_FACTOR: factor_reg = val[FACTOR_W-1:0];
      CFG_LIMIT:  limit_reg  = val[ELOAD_W-1:0];
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits above a narrow register carry junk
  task automatic apply_setting(input bit [ACT_W-1:0] act, input bit [FACTOR_W-1:0] fac,
                               input bit [ELOAD_W-1:0] lim);
    hold_off();
    write_reg(CFG_ACTIVE, CFG_W'({8'($urandom), act}));
    write_reg(CFG_FACTOR, CFG_W'({6'($urandom), fac}));
    write_reg(CFG_LIMIT, lim);
    n_settings++;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic sel_word_t mk_write(input int idx, input int cr, input bit en,
                                         input int smt, input int ld, input int thr,
                                         input bit idle);
    sel_word_t w;
    w      = '0;
    w.cmd  = CMD_WRITE;
    w.idx  = 5'(idx);
    w.core = CORE_W'(cr);
    w.en   = en;
    w.smt  = SMT_W'(smt);
    w.load = LOAD_W'(ld);
    w.thr  = THR_W'(thr);
    w.idle = idle;
    return w;
  endfunction

  function automatic sel_word_t mk_choose(input int cr, input bit [MASK_W-1:0] mask,
                                          input int prev, input int pin, input int cur);
    sel_word_t w;
    w      = '0;
    w.cmd  = CMD_CHOOSE;
    w.core = CORE_W'(cr);
    w.mask = mask;
    w.prev = 6'(prev);
    w.pin  = 6'(pin);
    w.cur  = 6'(cur);
    return w;
  endfunction

  // crowd packs most cpus onto two cores and one smt id with heavy loads
  function automatic sel_word_t rand_word(input bit crowd);
    sel_word_t w;
    w.cmd = ($urandom_range(0, 99) < 55) ? CMD_CHOOSE : CMD_WRITE;
    w.idx = 5'($urandom);
    if ($urandom_range(0, 7) == 0) w.core = CORE_W'($urandom);
    else w.core = crowd ? CORE_W'($urandom_range(0, 1)) : CORE_W'($urandom_range(0, 3));
    w.en = ($urandom_range(0, 6) != 0);
    if ($urandom_range(0, 4) == 0) w.smt = SMT_W'($urandom);
    else if (crowd) w.smt = ($urandom_range(0, 3) == 0) ? SMT_NONE : '0;
    else w.smt = SMT_W'($urandom_range(0, 3)) - SMT_W'(1);
    if (crowd && $urandom_range(0, 1) == 0) w.load = LOAD_W'($urandom_range(1536, 2047));
    else if (!crowd && $urandom_range(0, 9) < 3) w.load = LOAD_W'($urandom_range(0, 4) * 256);
    else w.load = LOAD_W'($urandom);
    w.thr  = ($urandom_range(0, 9) < 4) ? THR_W'($urandom_range(0, 3)) : THR_W'($urandom);
    w.idle = 1'($urandom);
    case ($urandom_range(0, 3))
      0: w.mask = '0;
      1: w.mask = $urandom;
      2: w.mask = '1;
      default: w.mask = $urandom & $urandom & $urandom;
    endcase
    w.prev = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, 31)) : 6'($urandom);
    case ($urandom_range(0, 19))
      15, 16, 17: w.pin = 6'($urandom_range(1, 32));
      18, 19:     w.pin = 6'($urandom_range(33, 63));
      default:    w.pin = '0;
    endcase
    w.cur = $urandom_range(0, 1) ? w.prev : 6'($urandom);
    return w;
  endfunction

  task automatic run_random(input int count, input bit crowd);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      // now and then let the block run dry before the next word
      if ($urandom_range(0, 59) == 0) hold_off();
      send_word(rand_word(crowd));
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases;
    send_word(mk_choose(0, '0, -1, 0, -1));               // empty table, nothing found
    send_word(mk_write(0, 3, 1, 2, 1024, 100, 0));
    send_word(mk_write(1, 3, 1, 2, 2047, 65535, 1));
    send_word(mk_write(2, 3, 1, -1, 300, 5, 0));          // no smt id, no siblings
    send_word(mk_write(3, 3, 1, -16, 300, 5, 0));
    send_word(mk_write(31, 31, 1, 15, 0, 0, 1));
    send_word(mk_write(30, 31, 0, 15, 2047, 65535, 1));   // disabled sibling
    send_word(mk_choose(3, '0, -1, 0, -1));               // full tie, lower index
    send_word(mk_choose(3, '0, 3, 0, 3));                 // light previous cpu kept
    send_word(mk_choose(3, 32'h1, 0, 0, 0));              // heavy previous cpu dropped
    send_word(mk_choose(3, '0, -1, 32, 31));              // pin to another core
    send_word(mk_choose(7, 32'h2, -1, 1, 0));             // pin ignores core and mask
    send_word(mk_choose(31, 32'h4000_0000, -1, 0, 5));    // only a disabled cpu allowed
    send_word(mk_choose(31, '1, 31, 0, -32));
    send_word(mk_choose(3, '0, 2, 63, 2));                // pin out of range, first usable
    send_word(mk_write(3, 3, 1, -16, 300, 4, 0));         // tie goes to fewer threads
    send_word(mk_choose(3, '0, -1, 0, 2));
    send_word(mk_write(2, 3, 1, -16, 300, 5, 0));         // negative id shared as siblings
    send_word(mk_choose(3, '0, -1, 0, 3));
    send_word(mk_write(1, 3, 0, 2, 2047, 65535, 1));
    send_word(mk_choose(3, 32'h3, 0, 0, 0));
    send_word(mk_choose(31, 32'h8000_0000, 30, 0, 31));
  endtask

  task automatic test_random_reset_regs;
    run_random(320, 1'b0);
  endtask

  task automatic test_single_cpu;
    apply_setting(6'd1, 8'd255, 14'd0);
    write_reg(CFG_SPARE, CFG_W'($urandom));  // unused slot, no effect
    run_random(300, 1'b0);
  endtask

  task automatic test_sibling_saturation;
    apply_setting(6'd63, 8'd255, 14'd16383);
    run_random(320, 1'b1);
  endtask

  task automatic test_no_cpus;
    apply_setting(6'd0, 8'd0, 14'd768);
    run_random(60, 1'b0);
  endtask

  task automatic test_partial_table;
    apply_setting(6'd17, 8'd64, 14'd1500);
    run_random(300, 1'b0);
  endtask

  task automatic test_clamped_count;
    apply_setting(6'd33, 8'd0, 14'd0);
    run_random(300, 1'b1);
  endtask

  task automatic test_mixed_weights;
    apply_setting(6'd32, 8'd200, 14'd3000);
    run_random(330, 1'b0);
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      n_results++;
      if (expected_q.size() == 0) begin
        flag_error($sformatf("unexpected result cpu %0d found %0b", chosen_cpu, found));
      end else begin
        head = expected_q.pop_front();
        if (found !== head.found)
          flag_error($sformatf("found %0b, expected %0b", found, head.found));
        if (chosen_cpu !== head.cpu)
          flag_error($sformatf("chosen_cpu %0d, expected %0d", chosen_cpu, head.cpu));
        if (reschedule !== head.resched)
          flag_error($sformatf("reschedule %0b, expected %0b", reschedule, head.resched));
        if (chosen_load !== head.eload)
          flag_error($sformatf("chosen_load %0d, expected %0d", chosen_load, head.eload));
      end
    end
  end

  // ---------------------------------------------------------------- main

  initial begin
    rst           <= 1'b1;
    start         <= 1'b0;
    command       <= CMD_WRITE;
    cpu_index     <= '0;
    core          <= '0;
    enabled       <= 1'b0;
    smt_id        <= '0;
    load          <= '0;
    thread_count  <= '0;
    running_idle  <= 1'b0;
    affinity_mask <= '0;
    last_cpu      <= '0;
    pinned_cpu    <= '0;
    current_cpu   <= '0;
    cfg_write     <= 1'b0;
    cfg_index     <= CFG_ACTIVE;
    cfg_data      <= '0;
    for (int i = 0; i < NUM_CPUS_DEF; i++) cpu_tbl[i] = '0;
    act_reg    = ACTIVE_RST;
    factor_reg = FACTOR_RST;
    limit_reg  = LIMIT_RST;
    start_up   = 1'b0;
    next_gap   = 0;
    calm       = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_reset_regs();
    test_single_cpu();
    test_sibling_saturation();
    test_no_cpus();
    test_partial_table();
    test_clamped_count();
    test_mixed_weights();
    hold_off();

    $display("covered %0d table writes and %0d chooses, %0d results checked",
             n_writes, n_chooses, n_results);
    $display("register settings applied: %0d, mismatches: %0d", n_settings, n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("watchdog expired, %0d results outstanding", expected_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
